[design/mixture_component_sampler_unit_assert.svh]
// Assertion macros for the mixture component sampler.
`ifndef MIXTURE_COMPONENT_SAMPLER_UNIT_ASSERT_SVH
`define MIXTURE_COMPONENT_SAMPLER_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define MCS_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
	else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MCS_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
	else $error("assertion failed");
`endif

[design/mcs_pkg.sv]
// Package with shared types and constants of the mixture component sampler.
package mcs_pkg;
	localparam int unsigned LN2_Q16 = 45426;
	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
	localparam logic [1:0] KIND_PRE = 2'd0;
	localparam logic [1:0] KIND_MEAN = 2'd1;
	localparam logic [1:0] KIND_IVAR = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// Operation codes of the shared multiplier.
	typedef enum logic [1:0] {
		MUL_SQ,
		MUL_VAR,
		MUL_EXP,
		MUL_TGT
	} mul_op_t;

	typedef struct packed {
		logic    go;
		mul_op_t op;
		logic [31:0] a;
		logic [31:0] b;
	} mul_req_t;
endpackage

[design/mcs_if.sv]
// Valid/ready channel interfaces for the sampler input and result words.
interface mcs_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [3:0]  coef_index;
	logic [1:0]  coef_kind;
	logic signed [31:0] coef_value;
	logic signed [31:0] sample_value;
	logic [15:0] uniform_draw;
	logic        last_sample;
	modport source(output valid, cmd, coef_index, coef_kind, coef_value, sample_value,
		uniform_draw, last_sample, input ready);
	modport sink(input valid, cmd, coef_index, coef_kind, coef_value, sample_value,
		uniform_draw, last_sample, output ready);
endinterface

interface mcs_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] component;
	logic       last_out;
	modport source(output valid, component, last_out, input ready);
	modport sink(input valid, component, last_out, output ready);
endinterface

[design/mixture_component_sampler_unit.sv]
// Mixture component sampler: ten-way weighted draw with iterative shared multiplier.
// A load word leaves the sequencer idle, so the input stays ready for the next word.
// A sample word is worked through one component at a time for its weight (read, square,
// variance scale, range reduction, five series terms, accumulate), then the target and
// a search over the components: one word is in work at a time, and the next sample word
// is accepted only after the result has been taken. Asynchronous active-low reset clears
// the sequencer; coefficient and cdf tables are not reset.
module mixture_component_sampler_unit import mcs_pkg::*; #(
	parameter int COMPONENTS = 10,
	parameter int DATA_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	mcs_in_if.sink    in_ch,
	mcs_out_if.source out_ch
);
	`include "mixture_component_sampler_unit_assert.svh"

	localparam int IW = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
	localparam int DW = DATA_WIDTH;
	// Exponent argument width: the wider of the data and the 32-bit product, plus headroom.
	localparam int AW = ((DW > 32) ? DW : 32) + 3;

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_SQ, S_SQW, S_VAR, S_VARW, S_EXPI, S_TERM, S_TERMW, S_ACC,
		S_TGT, S_TGTW, S_SRCH, S_OUT
	} state_t;

	state_t state_q;
	logic [IW-1:0] idx_q;
	logic [2:0] n_q;
	logic signed [DW-1:0] pre_mem [COMPONENTS];
	logic signed [DW-1:0] mean_mem [COMPONENTS];
	logic signed [DW-1:0] ivar_mem [COMPONENTS];
	logic [31:0] cdf_mem [COMPONENTS];
	logic signed [DW-1:0] pre_q, mean_q, ivar_q, x_q;
	logic [15:0] u_q;
	logic last_q;
	logic [31:0] r_q, t_q, s_q, acc_q, tgt_q;
	logic signed [AW-1:0] a_q;
	logic signed [7:0] k_q;
	logic [3:0] comp_q;
	logic [31:0] cdf_rd_q;
	logic found_q;
	mul_req_t req;
	logic [31:0] mres;

	mcs_mul u_mul (.clk(clk), .req(req), .res(mres));

	// Difference magnitude and clamped inverse variance.
	logic signed [DW:0] d;
	logic [DW:0] dm;
	logic [31:0] m32, iv32;
	logic [DW-1:0] ivm;
	assign d = {x_q[DW-1], x_q} - {mean_q[DW-1], mean_q};
	assign dm = d[DW] ? (~d + 1'b1) : d;
	assign ivm = ivar_q[DW-1] ? (~ivar_q + 1'b1) : ivar_q;
	always_comb begin
		m32 = (dm > (DW+1)'(SAT32)) ? SAT32 : 32'(dm);
		iv32 = (ivar_q[DW-1] || ({1'b0, ivm} > (DW+1)'(32'h7FFF_FFFF)))
			? 32'h7FFF_FFFF : 32'(ivm);
		if (ivar_q[DW-1] && ivm <= DW'(32'h7FFF_FFFF)) iv32 = 32'(ivm);
	end

	// Multiplier request for the current step.
	always_comb begin
		req = '0;
		case (state_q)
			S_SQ: begin req.go = 1'b1; req.op = MUL_SQ; req.a = m32; req.b = m32; end
			S_VAR: begin req.go = 1'b1; req.op = MUL_VAR; req.a = mres; req.b = iv32; end
			S_TERM: begin req.go = 1'b1; req.op = MUL_EXP; req.a = t_q; req.b = r_q; end
			S_TGT: begin req.go = 1'b1; req.op = MUL_TGT; req.a = {16'd0, u_q}; req.b = acc_q; end
			default: req = '0;
		endcase
	end

	// Range reduction by ln 2: floor quotient through a small walk is avoided by a
	// reciprocal estimate and one correction step.
	logic signed [AW-1:0] a_new;
	logic signed [63:0] qe;
	logic signed [7:0] ke;
	logic signed [DW+34:0] rem0;
	always_comb begin
		a_new = AW'(pre_q) - (ivar_q[DW-1] ? -$signed(AW'(mres)) : $signed(AW'(mres)));
		qe = ($signed(64'(a_q)) * 64'sd94548) >>> 32;
		ke = 8'(qe);
		rem0 = (DW+35)'(a_q) - (DW+35)'(ke) * (DW+35)'(LN2_Q16);
	end

	// Series term divided by n through a small constant reciprocal table.
	logic [31:0] tdiv;
	always_comb begin
		case (n_q)
			3'd1: tdiv = mres;
			3'd2: tdiv = mres >> 1;
			3'd3: tdiv = 32'((64'(mres) * 64'h5555_5556) >> 32);
			3'd4: tdiv = mres >> 2;
			3'd5: tdiv = 32'((64'(mres) * 64'h3333_3334) >> 32);
			default: tdiv = mres;
		endcase
	end

	// Final weight from series sum and exponent.
	logic [31:0] w;
	logic [63:0] sh;
	always_comb begin
		sh = '0;
		if (a_q > AW'(6*65536)) w = SAT32;
		else if (a_q < -AW'(17*65536)) w = '0;
		else if (k_q >= 0) begin
			sh = 64'(s_q) << k_q[3:0];
			w = (sh[63:32] != 0) ? SAT32 : sh[31:0];
		end else begin
			w = s_q >> (-k_q);
		end
	end

	logic [32:0] accsum;
	assign accsum = {1'b0, acc_q} + {1'b0, w};

	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.component = comp_q;
	assign out_ch.last_out = last_q;

	// Coefficient and cdf tables.
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready && in_ch.cmd == CMD_LOAD
			&& {1'b0, in_ch.coef_index} < 5'(COMPONENTS)) begin
			case (in_ch.coef_kind)
				KIND_PRE:  pre_mem[in_ch.coef_index[IW-1:0]] <= DW'(in_ch.coef_value);
				KIND_MEAN: mean_mem[in_ch.coef_index[IW-1:0]] <= DW'(in_ch.coef_value);
				KIND_IVAR: ivar_mem[in_ch.coef_index[IW-1:0]] <= DW'(in_ch.coef_value);
				default: ;
			endcase
		end
		if (state_q == S_RD) begin
			pre_q <= pre_mem[idx_q];
			mean_q <= mean_mem[idx_q];
			ivar_q <= ivar_mem[idx_q];
		end
		if (state_q == S_ACC) cdf_mem[idx_q] <= accsum[32] ? SAT32 : accsum[31:0];
		cdf_rd_q <= cdf_mem[idx_q];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			n_q <= '0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_ch.valid && in_ch.cmd == CMD_SAMPLE) begin
					x_q <= DW'(in_ch.sample_value);
					u_q <= in_ch.uniform_draw;
					last_q <= in_ch.last_sample;
					idx_q <= '0;
					acc_q <= '0;
					state_q <= S_RD;
				end
				S_RD: state_q <= S_SQ;
				S_SQ: state_q <= S_SQW;
				S_SQW: state_q <= S_VAR;
				S_VAR: state_q <= S_VARW;
				S_VARW: begin a_q <= a_new; state_q <= S_EXPI; end
				S_EXPI: begin
					if (rem0 < 0) begin
						k_q <= ke - 8'sd1;
						r_q <= 32'(rem0 + (DW+35)'(LN2_Q16)) << 8;
					end else if (rem0 >= (DW+35)'(LN2_Q16)) begin
						k_q <= ke + 8'sd1;
						r_q <= 32'(rem0 - (DW+35)'(LN2_Q16)) << 8;
					end else begin
						k_q <= ke;
						r_q <= 32'(rem0) << 8;
					end
					t_q <= 32'h0100_0000;
					s_q <= 32'h0100_0000;
					n_q <= 3'd1;
					state_q <= S_TERM;
				end
				S_TERM: state_q <= S_TERMW;
				S_TERMW: begin
					t_q <= tdiv;
					s_q <= s_q + tdiv;
					if (n_q == 3'd5) state_q <= S_ACC;
					else begin n_q <= n_q + 3'd1; state_q <= S_TERM; end
				end
				S_ACC: begin
					acc_q <= accsum[32] ? SAT32 : accsum[31:0];
					if (idx_q == IW'(COMPONENTS-1)) state_q <= S_TGT;
					else begin idx_q <= idx_q + 1'b1; state_q <= S_RD; end
				end
				S_TGT: state_q <= S_TGTW;
				S_TGTW: begin
					tgt_q <= mres;
					idx_q <= '0;
					n_q <= 3'd0;
					found_q <= 1'b0;
					comp_q <= 4'(COMPONENTS-1);
					state_q <= S_SRCH;
				end
				S_SRCH: begin
					// cdf_rd_q holds the registered read of the entry addressed by idx_q.
					if (n_q == 3'd0) n_q <= 3'd1;
					else begin
						if (!found_q && tgt_q <= cdf_rd_q) begin
							found_q <= 1'b1;
							comp_q <= 4'(idx_q);
						end
						if (idx_q == IW'(COMPONENTS-1)) state_q <= S_OUT;
						else idx_q <= idx_q + 1'b1;
						n_q <= 3'd0;
					end
				end
				S_OUT: if (out_ch.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`MCS_ASSERT_IMP(a_ready_idle, in_ch.ready, !out_ch.valid)
	`MCS_ASSERT_IMP(a_comp_range, out_ch.valid, {1'b0, out_ch.component} < 5'(COMPONENTS))
	`MCS_ASSERT_NXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.component))
endmodule

[design/mcs_mul.sv]
// Shared registered 32x32 unsigned multiplier with the shifts that follow it.
module mcs_mul import mcs_pkg::*; (
	input  logic        clk,
	input  mul_req_t    req,
	output logic [31:0] res
);
	logic [63:0] prod;
	logic [63:0] shifted;

	assign prod = {32'd0, req.a} * {32'd0, req.b};

	// Per-operation scaling of the product; clamping follows at the result register.
	always_comb begin
		case (req.op)
			MUL_SQ:  shifted = prod >> 16;
			MUL_VAR: shifted = prod >> 16;
			MUL_EXP: shifted = prod >> 24;
			MUL_TGT: shifted = prod >> 16;
			default: shifted = prod;
		endcase
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			res <= (shifted[63:32] != 32'd0) ? SAT32 : shifted[31:0];
		end
	end
endmodule

[dv/tb_mixture_component_sampler_unit.sv]
// Testbench for the mixture component sampler: directed table plus random words, self-checked.
module tb_mixture_component_sampler_unit;
	import mcs_pkg::*;

	localparam int NCOMP = 10;
	localparam int IDLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 400;

	typedef struct packed {
		logic        last;
		logic [3:0]  comp;
	} pick_t;

	typedef struct {
		logic        cmd;
		logic [3:0]  idx;
		logic [1:0]  kind;
		logic [31:0] cval;
		logic [31:0] xval;
		logic [15:0] u;
		logic        last;
		bit          has_fixed;
		logic [3:0]  fixed_comp;
	} stim_t;

	logic clk;
	logic arst_n;
	mcs_in_if  in_ch();
	mcs_out_if out_ch();

	mixture_component_sampler_unit #(.COMPONENTS(NCOMP), .DATA_WIDTH(32)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Shadow copy of the coefficient tables.
	longint pre_tab [NCOMP];
	longint mean_tab [NCOMP];
	longint ivar_tab [NCOMP];

	pick_t picks_pending [$];
	int errors;
	int words_sent;
	int picks_seen;
	int idle_cycles;
	int send_idle_pct;
	int recv_idle_pct;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Fixed-point exp of a Q16.16 argument, giving unsigned Q8.24.
	function automatic longint unsigned exp_q824(longint a);
		longint k, rem;
		longint unsigned r, t, s, v;
		if (a > 64'sd6 * 65536)
			return 64'hFFFF_FFFF;
		if (a < -64'sd17 * 65536)
			return 0;
		k = a / 45426;
		rem = a - k * 45426;
		if (rem < 0) begin
			k--;
			rem += 45426;
		end
		r = longint'(rem) << 8;
		s = 64'd1 << 24;
		t = 64'd1 << 24;
		for (int n = 1; n <= 5; n++) begin
			t = ((t * r) >> 24) / n;
			s += t;
		end
		if (k >= 0) begin
			v = s << k;
			return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
		end
		return s >> (-k);
	endfunction

	// Applies a load word or predicts the component picked for a sample word.
	function automatic void predict_word(stim_t w);
		longint x, d, term, a;
		longint unsigned m, sq, iv, acc, tgt;
		longint unsigned cdf [NCOMP];
		pick_t p;
		if (w.cmd == CMD_LOAD) begin
			if (w.idx < NCOMP) begin
				case (w.kind)
					KIND_PRE:  pre_tab[w.idx] = longint'(signed'(w.cval));
					KIND_MEAN: mean_tab[w.idx] = longint'(signed'(w.cval));
					KIND_IVAR: ivar_tab[w.idx] = longint'(signed'(w.cval));
					default: ;
				endcase
			end
			return;
		end
		x = longint'(signed'(w.xval));
		acc = 0;
		for (int i = 0; i < NCOMP; i++) begin
			d = x - mean_tab[i];
			m = (d < 0) ? -d : d;
			if (m > 64'hFFFF_FFFF) m = 64'hFFFF_FFFF;
			sq = (m * m) >> 16;
			if (sq > 64'hFFFF_FFFF) sq = 64'hFFFF_FFFF;
			iv = (ivar_tab[i] < 0) ? -ivar_tab[i] : ivar_tab[i];
			if (iv > 64'h7FFF_FFFF) iv = 64'h7FFF_FFFF;
			term = longint'((sq * iv) >> 16);
			if (ivar_tab[i] < 0) term = -term;
			a = pre_tab[i] - term;
			acc += exp_q824(a);
			if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
			cdf[i] = acc;
		end
		tgt = (longint'(w.u) * cdf[NCOMP-1]) >> 16;
		p.comp = 4'(NCOMP - 1);
		for (int i = NCOMP - 1; i >= 0; i--)
			if (tgt <= cdf[i]) p.comp = 4'(i);
		p.last = w.last;
		if (w.has_fixed && p.comp != w.fixed_comp) begin
			$error("table row: field component expected %0d, predictor gives %0d",
				w.fixed_comp, p.comp);
			errors++;
		end
		picks_pending.push_back(p);
	endfunction

	// Drives one word and waits for its acceptance; valid stays high on return.
	task automatic send_word(stim_t w);
		if ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= w.cmd;
		in_ch.coef_index <= w.idx;
		in_ch.coef_kind <= w.kind;
		in_ch.coef_value <= w.cval;
		in_ch.sample_value <= w.xval;
		in_ch.uniform_draw <= w.u;
		in_ch.last_sample <= w.last;
		do @(posedge clk); while (!in_ch.ready);
		predict_word(w);
		words_sent++;
		@(negedge clk);
	endtask

	function automatic stim_t load_word(int idx, logic [1:0] kind, logic [31:0] v);
		stim_t w;
		w = '{default: '0};
		w.cmd = CMD_LOAD;
		w.idx = 4'(idx);
		w.kind = kind;
		w.cval = v;
		w.xval = $urandom;
		w.u = 16'($urandom);
		w.last = 1'($urandom);
		return w;
	endfunction

	function automatic stim_t sample_word(logic [31:0] x, logic [15:0] u, logic last);
		stim_t w;
		w = '{default: '0};
		w.cmd = CMD_SAMPLE;
		w.idx = 4'($urandom);
		w.kind = 2'($urandom);
		w.cval = $urandom;
		w.xval = x;
		w.u = u;
		w.last = last;
		return w;
	endfunction

	// Random Q16.16 value: mostly modest, sometimes any 32-bit pattern.
	function automatic logic [31:0] rand_coef(int span);
		if ($urandom_range(9) == 0)
			return $urandom;
		return 32'($signed($urandom_range(2 * span)) - span);
	endfunction

	task automatic load_random_set();
		for (int i = 0; i < NCOMP; i++) begin
			send_word(load_word(i, KIND_PRE, rand_coef(6 * 65536)));
			send_word(load_word(i, KIND_MEAN, rand_coef(4 * 65536)));
			send_word(load_word(i, KIND_IVAR, rand_coef(3 * 65536)));
		end
	endtask

	// Drops valid and waits until every pending pick has returned.
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		do @(negedge clk); while (picks_pending.size() != 0);
	endtask

	// Result side: random stalls.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare each result word against the oldest prediction.
	always @(posedge clk) begin
		pick_t exp_pick;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			picks_seen++;
			if (picks_pending.size() == 0) begin
				$error("result word with no prediction waiting: component %0d", out_ch.component);
				errors++;
			end else begin
				exp_pick = picks_pending.pop_front();
				if (out_ch.component !== exp_pick.comp) begin
					$error("component: expected %0d, actual %0d", exp_pick.comp, out_ch.component);
					errors++;
				end
				if (out_ch.last_out !== exp_pick.last) begin
					$error("last_out: expected %0d, actual %0d", exp_pick.last, out_ch.last_out);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles without any accepted word.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Directed table then random phases.
	initial begin
		stim_t table_rows [$];
		stim_t w;
		int n;
		errors = 0;
		words_sent = 0;
		picks_seen = 0;
		idle_cycles = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_LOAD;
		in_ch.coef_index = '0;
		in_ch.coef_kind = '0;
		in_ch.coef_value = '0;
		in_ch.sample_value = '0;
		in_ch.uniform_draw = '0;
		in_ch.last_sample = 1'b0;
		foreach (pre_tab[i]) begin
			pre_tab[i] = 0;
			mean_tab[i] = 0;
			ivar_tab[i] = 0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// All weights equal (zero exponent): cdf rises evenly, so u picks the slot.
		for (int i = 0; i < NCOMP; i++) begin
			table_rows.push_back(load_word(i, KIND_PRE, 32'h0));
			table_rows.push_back(load_word(i, KIND_MEAN, 32'h0));
			table_rows.push_back(load_word(i, KIND_IVAR, 32'h0));
		end
		// Ignored loads: index out of range and the unused kind.
		table_rows.push_back(load_word(15, KIND_PRE, 32'h7FFF_FFFF));
		table_rows.push_back(load_word(3, KIND_UNUSED, 32'h8000_0000));
		w = sample_word(32'h0, 16'h0, 1'b0);
		w.has_fixed = 1'b1; w.fixed_comp = 4'd0; table_rows.push_back(w);
		w = sample_word(32'h7FFF_FFFF, 16'hFFFF, 1'b1);
		w.has_fixed = 1'b1; w.fixed_comp = 4'd9; table_rows.push_back(w);
		w = sample_word(32'h8000_0000, 16'h8000, 1'b0);
		w.has_fixed = 1'b1; w.fixed_comp = 4'd4; table_rows.push_back(w);
		// Zero total: a very negative prefactor everywhere.
		for (int i = 0; i < NCOMP; i++)
			table_rows.push_back(load_word(i, KIND_PRE, 32'h8000_0000));
		w = sample_word(32'h1234_5678, 16'hFFFF, 1'b1);
		w.has_fixed = 1'b1; w.fixed_comp = 4'd0; table_rows.push_back(w);
		// Saturated weights: maximal prefactor and negative inverse variance.
		table_rows.push_back(load_word(2, KIND_PRE, 32'h7FFF_FFFF));
		table_rows.push_back(load_word(2, KIND_IVAR, 32'h8000_0000));
		table_rows.push_back(load_word(5, KIND_MEAN, 32'h7FFF_FFFF));
		table_rows.push_back(sample_word(32'h8000_0000, 16'h7FFF, 1'b0));
		table_rows.push_back(sample_word(32'h0001_0000, 16'h0001, 1'b1));
		foreach (table_rows[r])
			send_word(table_rows[r]);

		// Three idling phases of random series.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 63 : 0;
			recv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 35 : 0;
			n = 0;
			while (n < 360) begin
				load_random_set();
				n += 3 * NCOMP;
				for (int s = 0; s < 40; s++) begin
					if ($urandom_range(19) == 0) begin
						// Noise: a stray load that may be ignored or rewrite one entry.
						w = load_word($urandom_range(15), 2'($urandom_range(3)),
							rand_coef(8 * 65536));
						send_word(w);
					end
					send_word(sample_word(rand_coef(6 * 65536), 16'($urandom), s == 39));
					n++;
				end
				// In the first phase, while n is below 100, hold off until every pending pick has returned.
				if (ph == 0 && n < 100)
					wait_drained();
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Sent %0d words (loads, ignored loads, samples) over three stall mixes.",
			words_sent);
		$display("Checked %0d component picks, including zero-total and saturated weights.",
			picks_seen);
		if (errors == 0 && picks_pending.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

[mixture_component_sampler_unit.f]
+incdir+design
design/mcs_pkg.sv
design/mcs_if.sv
design/mcs_mul.sv
design/mixture_component_sampler_unit.sv
dv/tb_mixture_component_sampler_unit.sv
